/* hw/rtl/acsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_pkg
// Shared types, constants and helpers of the addressed CSV command parser.
// ----------------------------------------------------------------------------
package acsv_pkg;

    localparam int VALUE_W             = 32;
    localparam int ADDR_CHARS_W        = 32;
    localparam int ADDR_LEN_W          = 3;
    localparam int MAX_ADDRESS_CHARS   = 4;
    localparam int ADDR_CMP_LIMIT      = (MAX_ADDRESS_CHARS < 4) ? MAX_ADDRESS_CHARS : 4;
    localparam int FRACTION_DIGITS_DEF = 3;
    localparam int FRACTION_DIGITS_MAX = 6;
    localparam int SCALE_W             = 20;
    localparam int POW_IDX_W           = 3;
    localparam int CFG_IDX_W           = 1;

    localparam logic [ADDR_LEN_W-1:0]   TEXT_LEN_MAX      = 3'd7;
    localparam logic [ADDR_CHARS_W-1:0] ADDR_CHARS_RESET  = 32'h3100_0000;
    localparam logic [ADDR_LEN_W-1:0]   ADDR_LEN_RESET    = 3'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_CHARS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LEN   = 1'd1;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [VALUE_W-1:0] VALUE_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_NEG_SAT = 32'h8000_0000;

    typedef enum logic [2:0] {
        K_NEWLINE,
        K_COMMA,
        K_SPACE,
        K_PLUS,
        K_MINUS,
        K_DIGIT,
        K_POINT,
        K_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        NP_LEAD,
        NP_INT,
        NP_FRAC,
        NP_STOP
    } t_num_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_token;

    function automatic logic [SCALE_W-1:0] pow10(input logic [POW_IDX_W-1:0] n);
        logic [SCALE_W-1:0] r;
        unique case (n)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/acsv_rx_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_rx_if
// Received character channel.
// ----------------------------------------------------------------------------
interface acsv_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/acsv_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_res_if
// Result channel: start angle, distance and end angle in thousandths.
// ----------------------------------------------------------------------------
interface acsv_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_angle_milli;
    logic signed [31:0] travel_dist_milli;
    logic signed [31:0] end_angle_milli;

    modport source (output valid, output start_angle_milli, output travel_dist_milli,
                    output end_angle_milli, input ready);
    modport sink   (input valid, input start_angle_milli, input travel_dist_milli,
                    input end_angle_milli, output ready);
endinterface

/* hw/rtl/acsv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_front
// Takes received characters and classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
module acsv_front (
    acsv_rx_if.sink        i_rx,
    output logic           o_tok_valid,
    input  logic           i_tok_ready,
    output acsv_pkg::t_token o_tok
);

    acsv_pkg::t_kind w_kind;

    always_comb begin
        unique case (i_rx.rx_byte) inside
            acsv_pkg::CH_NEWLINE: w_kind = acsv_pkg::K_NEWLINE;
            acsv_pkg::CH_COMMA:   w_kind = acsv_pkg::K_COMMA;
            acsv_pkg::CH_SPACE, acsv_pkg::CH_TAB, [acsv_pkg::CH_VT:acsv_pkg::CH_CR]:
                                  w_kind = acsv_pkg::K_SPACE;
            acsv_pkg::CH_PLUS:    w_kind = acsv_pkg::K_PLUS;
            acsv_pkg::CH_MINUS:   w_kind = acsv_pkg::K_MINUS;
            acsv_pkg::CH_POINT:   w_kind = acsv_pkg::K_POINT;
            [acsv_pkg::CH_ZERO:acsv_pkg::CH_NINE]:
                                  w_kind = acsv_pkg::K_DIGIT;
            default:              w_kind = acsv_pkg::K_OTHER;
        endcase
    end

    assign o_tok.kind  = w_kind;
    assign o_tok.ch    = i_rx.rx_byte;
    assign o_tok_valid = i_rx.valid;
    assign i_rx.ready  = i_tok_ready;

endmodule

/* hw/rtl/acsv_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_queue
// Two-entry token queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module acsv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  acsv_pkg::t_token i_in_tok,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output acsv_pkg::t_token o_out_tok
);

    acsv_pkg::t_token r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_tok   = r_mem[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_tok;
        end
    end

endmodule

/* hw/rtl/acsv_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_back
// Executes tokens: address match, number conversion, slot rotation, result.
// ----------------------------------------------------------------------------
module acsv_back #(
    parameter int FRACTION_DIGITS = acsv_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acsv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acsv_pkg::ADDR_CHARS_W-1:0] i_cfg_data,
    input  logic                              i_tok_valid,
    output logic                              o_tok_ready,
    input  acsv_pkg::t_token                  i_tok,
    acsv_res_if.source                        o_res
);

    localparam int FSEEN_W = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam int VW      = acsv_pkg::VALUE_W;
    localparam int MAG_W   = VW + acsv_pkg::SCALE_W;

    logic [acsv_pkg::ADDR_CHARS_W-1:0] r_addr_chars;
    logic [acsv_pkg::ADDR_LEN_W-1:0]   r_addr_len;

    logic                        r_addr_phase, n_addr_phase;
    logic                        r_matched,    n_matched;
    logic [1:0]                  r_slot,       n_slot;
    logic [VW-1:0]               r_slot0,      n_slot0;
    logic [VW-1:0]               r_slot1,      n_slot1;
    logic                        r_text_ok,    n_text_ok;
    logic [acsv_pkg::ADDR_LEN_W-1:0] r_text_len, n_text_len;
    logic [VW-1:0]               r_acc,        n_acc;
    logic                        r_neg,        n_neg;
    acsv_pkg::t_num_phase        r_phase,      n_phase;
    logic [FSEEN_W-1:0]          r_fseen,      n_fseen;
    logic                        r_out_valid,  n_out_valid;
    logic [VW-1:0]               r_out_start,  n_out_start;
    logic [VW-1:0]               r_out_dist,   n_out_dist;
    logic [VW-1:0]               r_out_end,    n_out_end;

    logic                        w_take;
    logic [VW+3:0]               w_acc_ext;
    logic [VW+3:0]               w_acc_mul;
    logic [VW-1:0]               w_acc_dig;
    logic [acsv_pkg::SCALE_W-1:0] w_scale;
    logic [MAG_W-1:0]            w_mag;
    logic                        w_sat;
    logic [VW-1:0]               w_value;
    logic [7:0]                  w_want;
    logic                        w_char_ok;

    assign o_tok_ready = !r_out_valid || o_res.ready;
    assign w_take      = i_tok_valid && o_tok_ready;

    // acc * 10 + digit, saturating
    assign w_acc_ext = {4'b0, r_acc};
    assign w_acc_mul = (w_acc_ext << 3) + (w_acc_ext << 1) + {{VW{1'b0}}, i_tok.ch[3:0]};
    assign w_acc_dig = (|w_acc_mul[VW+3:VW]) ? {VW{1'b1}} : w_acc_mul[VW-1:0];

    // scale missing fraction digits, then saturate to signed
    assign w_scale = acsv_pkg::pow10(acsv_pkg::POW_IDX_W'(FRACTION_DIGITS)
                                     - acsv_pkg::POW_IDX_W'(r_fseen));
    assign w_mag   = MAG_W'(r_acc) * MAG_W'(w_scale);
    assign w_sat   = |w_mag[MAG_W-1:VW-1];
    always_comb begin
        if (r_neg) begin
            w_value = w_sat ? acsv_pkg::VALUE_NEG_SAT : (VW'(0) - w_mag[VW-1:0]);
        end else begin
            w_value = w_sat ? acsv_pkg::VALUE_POS_SAT : w_mag[VW-1:0];
        end
    end

    assign w_want    = r_addr_chars[VW-1 - 8 * r_text_len[1:0] -: 8];
    assign w_char_ok = (r_text_len < r_addr_len)
                    && (r_text_len < acsv_pkg::ADDR_LEN_W'(acsv_pkg::ADDR_CMP_LIMIT))
                    && (w_want == i_tok.ch);

    always_comb begin
        n_addr_phase = r_addr_phase;
        n_matched    = r_matched;
        n_slot       = r_slot;
        n_slot0      = r_slot0;
        n_slot1      = r_slot1;
        n_text_ok    = r_text_ok;
        n_text_len   = r_text_len;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_phase      = r_phase;
        n_fseen      = r_fseen;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_start  = r_out_start;
        n_out_dist   = r_out_dist;
        n_out_end    = r_out_end;

        if (w_take) begin
            unique case (i_tok.kind)
                acsv_pkg::K_NEWLINE: begin
                    n_addr_phase = 1'b1;
                    n_matched    = 1'b0;
                    n_slot       = 2'd0;
                end
                acsv_pkg::K_COMMA: begin
                    if (r_matched) begin
                        if (r_slot >= 2'd2) begin
                            n_out_valid = 1'b1;
                            n_out_start = r_slot0;
                            n_out_dist  = r_slot1;
                            n_out_end   = w_value;
                            n_slot      = 2'd0;
                        end else begin
                            if (r_slot == 2'd0) begin
                                n_slot0 = w_value;
                            end else begin
                                n_slot1 = w_value;
                            end
                            n_slot = r_slot + 2'd1;
                        end
                    end
                    if (r_addr_phase && r_text_ok && (r_text_len == r_addr_len)) begin
                        n_matched = 1'b1;
                    end
                    n_addr_phase = 1'b0;
                    n_text_ok    = 1'b1;
                    n_text_len   = '0;
                    n_acc        = '0;
                    n_neg        = 1'b0;
                    n_phase      = acsv_pkg::NP_LEAD;
                    n_fseen      = '0;
                end
                default: begin
                    if (!w_char_ok) begin
                        n_text_ok = 1'b0;
                    end
                    if (r_text_len < acsv_pkg::TEXT_LEN_MAX) begin
                        n_text_len = r_text_len + acsv_pkg::ADDR_LEN_W'(1);
                    end
                    unique case (r_phase)
                        acsv_pkg::NP_LEAD: begin
                            unique case (i_tok.kind)
                                acsv_pkg::K_SPACE: ;
                                acsv_pkg::K_PLUS: begin
                                    n_neg   = 1'b0;
                                    n_phase = acsv_pkg::NP_INT;
                                end
                                acsv_pkg::K_MINUS: begin
                                    n_neg   = 1'b1;
                                    n_phase = acsv_pkg::NP_INT;
                                end
                                acsv_pkg::K_DIGIT: begin
                                    n_acc   = w_acc_dig;
                                    n_phase = acsv_pkg::NP_INT;
                                end
                                acsv_pkg::K_POINT: n_phase = acsv_pkg::NP_FRAC;
                                default:           n_phase = acsv_pkg::NP_STOP;
                            endcase
                        end
                        acsv_pkg::NP_INT: begin
                            unique case (i_tok.kind)
                                acsv_pkg::K_DIGIT: n_acc   = w_acc_dig;
                                acsv_pkg::K_POINT: n_phase = acsv_pkg::NP_FRAC;
                                default:           n_phase = acsv_pkg::NP_STOP;
                            endcase
                        end
                        acsv_pkg::NP_FRAC: begin
                            if (i_tok.kind == acsv_pkg::K_DIGIT) begin
                                if (r_fseen < FSEEN_W'(FRACTION_DIGITS)) begin
                                    n_acc   = w_acc_dig;
                                    n_fseen = r_fseen + FSEEN_W'(1);
                                end
                            end else begin
                                n_phase = acsv_pkg::NP_STOP;
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_chars <= acsv_pkg::ADDR_CHARS_RESET;
            r_addr_len   <= acsv_pkg::ADDR_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                acsv_pkg::CFG_ADDR_CHARS: r_addr_chars <= i_cfg_data;
                acsv_pkg::CFG_ADDR_LEN:   r_addr_len   <= i_cfg_data[acsv_pkg::ADDR_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_phase <= 1'b0;
            r_matched    <= 1'b0;
            r_slot       <= 2'd0;
            r_slot0      <= '0;
            r_slot1      <= '0;
            r_text_ok    <= 1'b1;
            r_text_len   <= '0;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_phase      <= acsv_pkg::NP_LEAD;
            r_fseen      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_addr_phase <= n_addr_phase;
            r_matched    <= n_matched;
            r_slot       <= n_slot;
            r_slot0      <= n_slot0;
            r_slot1      <= n_slot1;
            r_text_ok    <= n_text_ok;
            r_text_len   <= n_text_len;
            r_acc        <= n_acc;
            r_neg        <= n_neg;
            r_phase      <= n_phase;
            r_fseen      <= n_fseen;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_start <= n_out_start;
        r_out_dist  <= n_out_dist;
        r_out_end   <= n_out_end;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.start_angle_milli = r_out_start;
    assign o_res.travel_dist_milli = r_out_dist;
    assign o_res.end_angle_milli   = r_out_end;

endmodule

/* hw/rtl/addressed_csv_command_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_csv_command_parser
// Line/field parser: matches a node address, converts three fields to
// signed thousandths and emits them as one result.
//
// Channel   Dir  Payload                                    Transfer when
// i_rx      in   rx_byte[7:0]                               valid && ready
// o_res     out  start_angle_milli, travel_dist_milli,      valid && ready
//                end_angle_milli (32b signed each)
// i_cfg_*   in   index[0], data[31:0]                       i_cfg_we
//
// One character per cycle sustained unless a result waits on a stalled
// receiver. A character passes through the queue to the executor; a result
// is registered after its comma. Reset is synchronous. A two-entry queue
// absorbs output stalls; input ready drops only when it is full.
// ----------------------------------------------------------------------------
module addressed_csv_command_parser #(
    parameter int FRACTION_DIGITS = acsv_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acsv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [acsv_pkg::ADDR_CHARS_W-1:0] i_cfg_data,
    acsv_rx_if.sink                           i_rx,
    acsv_res_if.source                        o_res
);

    logic             w_f_valid;
    logic             w_f_ready;
    acsv_pkg::t_token w_f_tok;
    logic             w_b_valid;
    logic             w_b_ready;
    acsv_pkg::t_token w_b_tok;

    acsv_front u_front (
        .i_rx        (i_rx),
        .o_tok_valid (w_f_valid),
        .i_tok_ready (w_f_ready),
        .o_tok       (w_f_tok)
    );

    acsv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_f_valid),
        .o_in_ready  (w_f_ready),
        .i_in_tok    (w_f_tok),
        .o_out_valid (w_b_valid),
        .i_out_ready (w_b_ready),
        .o_out_tok   (w_b_tok)
    );

    acsv_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tok_valid (w_b_valid),
        .o_tok_ready (w_b_ready),
        .i_tok       (w_b_tok),
        .o_res       (o_res)
    );

endmodule

/* hw/rtl/acsv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsv_checker
// Port-level checks of the addressed CSV command parser.
// ----------------------------------------------------------------------------
module acsv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_res_start,
    input logic [31:0] i_res_dist,
    input logic [31:0] i_res_end
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_start) && $stable(i_res_dist) && $stable(i_res_end))
        else $error("result payload changed while stalled");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |=> i_rx_ready)
        else $error("input stalled with an empty output");

endmodule

bind addressed_csv_command_parser acsv_checker u_acsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_start (o_res.start_angle_milli),
    .i_res_dist  (o_res.travel_dist_milli),
    .i_res_end   (o_res.end_angle_milli)
);

/* test/tb_addressed_csv_command_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressed_csv_command_parser
// Self-checking bench for the addressed CSV command parser. A short table of
// command lines (address match and mismatch, number formats, saturation, line
// breaks inside fields) runs first. Then random lines follow under a series of
// node addresses. Every character transfer feeds a software parser, and each
// result transfer is checked field by field against the oldest predicted move.
// Bursty input and a stalling result receiver run throughout.
// ----------------------------------------------------------------------------
module tb_addressed_csv_command_parser;

    localparam int FRAC_DIGITS    = acsv_pkg::FRACTION_DIGITS_DEF;
    localparam int ADDR_REG_CHARS = acsv_pkg::ADDR_CHARS_W / 8;
    localparam int LAST_SLOT      = 2;
    localparam int RAND_BYTES     = 1130;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_PRINTED    = 100;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;

    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic signed [31:0] start_angle;
        logic signed [31:0] travel_dist;
        logic signed [31:0] end_angle;
    } t_move;

    typedef enum {ROW_PREDICT, ROW_NONE, ROW_ONE} t_row_check;
    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} t_ready_mode;

    typedef struct {
        bit          cfg_en;
        logic [31:0] chars;
        logic [2:0]  len;
        string       text;
        t_row_check  chk;
        int          start_angle;
        int          travel_dist;
        int          end_angle;
    } t_dir_row;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [acsv_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [acsv_pkg::ADDR_CHARS_W-1:0] i_cfg_data  = '0;

    acsv_rx_if  rx_ch();
    acsv_res_if res_ch();

    addressed_csv_command_parser #(
        .FRACTION_DIGITS(FRAC_DIGITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // parser shadow state
    logic [31:0]          node_chars    = acsv_pkg::ADDR_CHARS_RESET;
    logic [2:0]           node_len      = acsv_pkg::ADDR_LEN_RESET;
    bit                   in_addr_field = 1'b0;
    bit                   node_selected = 1'b0;
    int                   slot_idx      = 0;
    logic [31:0]          slot_val [2]  = '{32'd0, 32'd0};
    bit                   field_addr_ok = 1'b1;
    logic [2:0]           field_len     = '0;
    logic [31:0]          num_mag       = '0;
    bit                   num_neg       = 1'b0;
    acsv_pkg::t_num_phase num_phase     = acsv_pkg::NP_LEAD;
    int                   frac_cnt      = 0;

    t_move       pending_moves [$];
    logic [7:0]  tx_bytes [$];
    bit          typed_row   = 1'b0;
    int          typed_seen  = 0;

    int          error_count      = 0;
    int          bytes_queued     = 0;
    int          bytes_sent       = 0;
    int          moves_checked    = 0;
    int          address_settings = 0;
    int          cycle_count      = 0;
    int          burst_left       = 1;
    int          gap_left         = 0;
    int          mode_left        = 0;
    t_ready_mode ready_mode       = RDY_ALWAYS;
    t_move       got_move;
    t_move       want_move;

    t_dir_row    dir_rows [20];

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic void add_digit(input logic [7:0] ch);
        logic [35:0] v;
        v = num_mag * 36'd10 + (ch - acsv_pkg::CH_ZERO);
        num_mag = (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void parse_rx_char(input logic [7:0] ch);
        logic [63:0] mag;
        logic [31:0] value;
        bit          is_digit;
        bit          addr_hit;
        int          k;
        is_digit = (ch >= acsv_pkg::CH_ZERO && ch <= acsv_pkg::CH_NINE);
        if (ch == acsv_pkg::CH_NEWLINE) begin
            in_addr_field = 1'b1;
            node_selected = 1'b0;
            slot_idx      = 0;
        end else if (ch != acsv_pkg::CH_COMMA) begin
            addr_hit = 1'b0;
            if (field_len < node_len && field_len < ADDR_REG_CHARS
                    && field_len < acsv_pkg::MAX_ADDRESS_CHARS)
                addr_hit = (node_chars[acsv_pkg::ADDR_CHARS_W-1 - 8*field_len -: 8] == ch);
            if (!addr_hit) field_addr_ok = 1'b0;
            if (field_len < acsv_pkg::TEXT_LEN_MAX) field_len++;
            case (num_phase)
                acsv_pkg::NP_LEAD: begin
                    if (!(ch == acsv_pkg::CH_SPACE
                            || (ch >= acsv_pkg::CH_TAB && ch <= acsv_pkg::CH_CR))) begin
                        if (ch == acsv_pkg::CH_PLUS || ch == acsv_pkg::CH_MINUS) begin
                            num_neg   = (ch == acsv_pkg::CH_MINUS);
                            num_phase = acsv_pkg::NP_INT;
                        end else if (is_digit) begin
                            add_digit(ch);
                            num_phase = acsv_pkg::NP_INT;
                        end else if (ch == acsv_pkg::CH_POINT) begin
                            num_phase = acsv_pkg::NP_FRAC;
                        end else begin
                            num_phase = acsv_pkg::NP_STOP;
                        end
                    end
                end
                acsv_pkg::NP_INT: begin
                    if (is_digit) add_digit(ch);
                    else if (ch == acsv_pkg::CH_POINT) num_phase = acsv_pkg::NP_FRAC;
                    else num_phase = acsv_pkg::NP_STOP;
                end
                acsv_pkg::NP_FRAC: begin
                    if (is_digit) begin
                        if (frac_cnt < FRAC_DIGITS) begin
                            add_digit(ch);
                            frac_cnt++;
                        end
                    end else begin
                        num_phase = acsv_pkg::NP_STOP;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            if (node_selected) begin
                mag = {32'd0, num_mag};
                for (k = frac_cnt; k < FRAC_DIGITS; k++) mag = mag * 10;
                if (num_neg)
                    value = (mag >= 64'h8000_0000) ? acsv_pkg::VALUE_NEG_SAT
                                                   : -mag[31:0];
                else
                    value = (mag > 64'h7FFF_FFFF) ? acsv_pkg::VALUE_POS_SAT
                                                  : mag[31:0];
                if (slot_idx >= LAST_SLOT) begin
                    if (typed_row) typed_seen++;
                    else pending_moves.push_back({slot_val[0], slot_val[1], value});
                    slot_idx = 0;
                end else begin
                    slot_val[slot_idx] = value;
                    slot_idx++;
                end
            end
            if (in_addr_field && field_addr_ok && field_len == node_len) node_selected = 1'b1;
            in_addr_field = 1'b0;
            field_addr_ok = 1'b1;
            field_len     = '0;
            num_mag       = '0;
            num_neg       = 1'b0;
            num_phase     = acsv_pkg::NP_LEAD;
            frac_cnt      = 0;
        end
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void push_number();
        logic [7:0] ws [5] = '{acsv_pkg::CH_SPACE, acsv_pkg::CH_TAB, acsv_pkg::CH_VT,
                               CH_FF, acsv_pkg::CH_CR};
        logic [7:0] junk;
        int         n;
        int         digits;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_byte(ws[$urandom_range(0, 4)]);
        n = $urandom_range(0, 3);
        if (n == 1) push_byte(acsv_pkg::CH_PLUS);
        else if (n == 2) push_byte(acsv_pkg::CH_MINUS);
        n = $urandom_range(0, 15);
        digits = (n < 10) ? $urandom_range(0, 3) : (n < 14) ? $urandom_range(4, 7)
                                                             : $urandom_range(8, 12);
        repeat (digits) push_byte(8'(acsv_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1) begin
            push_byte(acsv_pkg::CH_POINT);
            repeat ($urandom_range(0, 5))
                push_byte(8'(acsv_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 7) == 0) begin
            junk = 8'($urandom_range(0, 255));
            if (junk == acsv_pkg::CH_NEWLINE || junk == acsv_pkg::CH_COMMA)
                junk = acsv_pkg::CH_POINT;
            push_byte(junk);
        end
    endfunction

    task automatic wait_link_idle();
        while (tx_bytes.size() != 0 || rx_ch.valid || pending_moves.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [acsv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == acsv_pkg::CFG_ADDR_CHARS) node_chars = data;
        else node_len = data[2:0];
    endtask

    task automatic set_node_address(input logic [31:0] chars, input logic [2:0] len);
        wait_link_idle();
        write_reg(acsv_pkg::CFG_ADDR_CHARS, chars);
        write_reg(acsv_pkg::CFG_ADDR_LEN, {29'd0, len});
        address_settings++;
    endtask

    // character source: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                parse_rx_char(rx_ch.rx_byte);
                bytes_sent++;
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (gap_left != 0) begin
                    rx_ch.valid <= 1'b0;
                    gap_left--;
                end else if (tx_bytes.size() != 0) begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= tx_bytes.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver stall pattern
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 200);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS:   res_ch.ready <= 1'b1;
            RDY_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: res_ch.ready <= (mode_left % 4) != 0;
            default:      res_ch.ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_move = {res_ch.start_angle_milli, res_ch.travel_dist_milli,
                        res_ch.end_angle_milli};
            if (pending_moves.size() == 0) begin
                report_error($sformatf("unexpected result %0d %0d %0d", got_move.start_angle,
                                       got_move.travel_dist, got_move.end_angle));
            end else begin
                want_move = pending_moves.pop_front();
                if (got_move.start_angle !== want_move.start_angle)
                    report_error($sformatf("start angle %0d, expected %0d",
                                           got_move.start_angle, want_move.start_angle));
                if (got_move.travel_dist !== want_move.travel_dist)
                    report_error($sformatf("distance %0d, expected %0d",
                                           got_move.travel_dist, want_move.travel_dist));
                if (got_move.end_angle !== want_move.end_angle)
                    report_error($sformatf("end angle %0d, expected %0d",
                                           got_move.end_angle, want_move.end_angle));
            end
            moves_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_moves.size());
            $display("addressed_csv_command_parser test failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] chars;
        logic [7:0]  addr_q [$];
        int          len;
        int          kind;
        int          nfields;
        int          phase_end;
        int          rand_start;
        int          i;
        int          j;

        // '@' in the text stands for a zero byte
        dir_rows = '{
            '{1'b0, 32'h0, 3'd0, "7,8,9,", ROW_NONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n1,1,2,3,", ROW_ONE, 1000, 2000, 3000},
            '{1'b0, 32'h0, 3'd0, "\n1, -1.5,+0.25,\t.5,", ROW_ONE, -1500, 250, 500},
            '{1'b0, 32'h0, 3'd0, "\n1,1.23456,-0,abc,", ROW_ONE, 1234, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n1,99999999999,-99999999999,2147483.647,", ROW_ONE,
              int'(acsv_pkg::VALUE_POS_SAT), int'(acsv_pkg::VALUE_NEG_SAT), 2147483647},
            '{1'b0, 32'h0, 3'd0, "\n1,-2147483.648,1e3,2x5,", ROW_ONE,
              int'(acsv_pkg::VALUE_NEG_SAT), 1000, 2000},
            '{1'b0, 32'h0, 3'd0, "\n1,inf,nan,@5,", ROW_ONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n1,+,-,.,", ROW_ONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n2,1,2,3,", ROW_NONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n11,1,2,3,", ROW_NONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n,1,2,3,", ROW_NONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n1,5\n1,1,2,3,", ROW_NONE, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n1,1,2,3,4,5,6,7,", ROW_PREDICT, 0, 0, 0},
            '{1'b0, 32'h0, 3'd0, "\n1,7,8\n1,4,5,6,", ROW_PREDICT, 0, 0, 0},
            '{1'b1, 32'h4142_0000, 3'd2, "\nAB,12,34,56,", ROW_ONE, 12000, 34000, 56000},
            '{1'b0, 32'h0, 3'd0, "\nA,1,2,3,\nABC,1,2,3,", ROW_NONE, 0, 0, 0},
            '{1'b1, 32'hFFFF_FFFF, 3'd4, "\n\377\377\377\377,1,2,3,", ROW_ONE,
              1000, 2000, 3000},
            '{1'b1, 32'h0, 3'd0, "\n,4,5,6,", ROW_ONE, 4000, 5000, 6000},
            '{1'b1, 32'h0, 3'd4, "\n@@@@,7,8,9,", ROW_ONE, 7000, 8000, 9000},
            '{1'b1, acsv_pkg::ADDR_CHARS_RESET, acsv_pkg::ADDR_LEN_RESET,
              "\n1,0.001,-0.0009,12345678901234567890,", ROW_ONE, 1, 0,
              int'(acsv_pkg::VALUE_POS_SAT)}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_en) set_node_address(dir_rows[r].chars, dir_rows[r].len);
            if (dir_rows[r].chk != ROW_PREDICT) begin
                wait_link_idle();
                typed_row  = 1'b1;
                typed_seen = 0;
                if (dir_rows[r].chk == ROW_ONE)
                    pending_moves.push_back({32'(dir_rows[r].start_angle),
                                             32'(dir_rows[r].travel_dist),
                                             32'(dir_rows[r].end_angle)});
            end
            for (i = 0; i < dir_rows[r].text.len(); i++)
                push_byte((dir_rows[r].text[i] == "@") ? CH_NUL : dir_rows[r].text[i]);
            if (dir_rows[r].chk != ROW_PREDICT) begin
                wait_link_idle();
                if (typed_seen != ((dir_rows[r].chk == ROW_ONE) ? 1 : 0))
                    report_error($sformatf("row %0d: parser model gives %0d results",
                                           r, typed_seen));
                typed_row = 1'b0;
            end
        end

        rand_start = bytes_queued;
        while (bytes_queued - rand_start < RAND_BYTES) begin
            len = $urandom_range(0, ADDR_REG_CHARS);
            for (i = 0; i < ADDR_REG_CHARS; i++) begin
                if ($urandom_range(0, 3) == 0)
                    chars[31 - 8*i -: 8] = 8'($urandom_range(0, 255));
                else
                    chars[31 - 8*i -: 8] = 8'($urandom_range(33, 126));
            end
            set_node_address(chars, 3'(len));
            phase_end = bytes_queued + $urandom_range(150, 350);
            while (bytes_queued < phase_end && bytes_queued - rand_start < RAND_BYTES) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_byte(acsv_pkg::CH_NEWLINE);
                    addr_q.delete();
                    for (i = 0; i < len; i++) addr_q.push_back(chars[31 - 8*i -: 8]);
                    // corrupted address: one char changed, one extra, or one missing
                    if (kind == 1) begin
                        j = $urandom_range(0, 2);
                        if (j == 0 && addr_q.size() != 0)
                            addr_q[$urandom_range(0, addr_q.size() - 1)] ^=
                                8'($urandom_range(1, 255));
                        else if (j == 1 || addr_q.size() == 0)
                            addr_q.push_back(8'($urandom_range(33, 126)));
                        else
                            void'(addr_q.pop_back());
                    end
                    foreach (addr_q[k]) push_byte(addr_q[k]);
                    push_byte(acsv_pkg::CH_COMMA);
                    nfields = ($urandom_range(0, 1) == 1) ? 3 : $urandom_range(1, 7);
                    for (i = 0; i < nfields; i++) begin
                        push_number();
                        if (i < nfields - 1 || $urandom_range(0, 9) != 0)
                            push_byte(acsv_pkg::CH_COMMA);
                    end
                end
            end
        end

        wait_link_idle();
        $display("ran %0d directed lines and random lines under %0d node addresses",
                 $size(dir_rows), address_settings);
        $display("%0d characters transferred, %0d moves checked, %0d mismatches",
                 bytes_sent, moves_checked, error_count);
        if (error_count == 0) begin
            $display("addressed_csv_command_parser test passed");
        end else begin
            $display("addressed_csv_command_parser test failed");
        end
        $finish;
    end

endmodule

/* addressed_csv_command_parser.f */
hw/rtl/acsv_pkg.sv
hw/rtl/acsv_rx_if.sv
hw/rtl/acsv_res_if.sv
hw/rtl/acsv_front.sv
hw/rtl/acsv_queue.sv
hw/rtl/acsv_back.sv
hw/rtl/addressed_csv_command_parser.sv
hw/rtl/acsv_checker.sv
test/tb_addressed_csv_command_parser.sv
